// File: src/pewp_pkg.sv
// -----------------------------------------------------------------------------
// pewp_pkg
// Shared constants, codes and types of the paired-end window pairing block.
// -----------------------------------------------------------------------------
package pewp_pkg;

  localparam int unsigned LIST_DEPTH       = 64;
  localparam int unsigned MAX_PAIR_OUTPUTS = 64;

  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(LIST_DEPTH);
  localparam int unsigned BUF_DEPTH  = (LIST_DEPTH > MAX_PAIR_OUTPUTS + 1) ?
                                       LIST_DEPTH : MAX_PAIR_OUTPUTS + 1;
  localparam int unsigned BUF_CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int unsigned BUF_ADDR_W = $clog2(BUF_DEPTH);

  localparam logic [7:0] LEAST_START = 8'd100;

  // input modes
  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_MATE = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // list status codes carried by the end marker
  localparam logic [1:0] LS_SKIPPED   = 2'd1;
  localparam logic [1:0] LS_UNHANDLED = 2'd2;
  localparam logic [1:0] LS_RESERVED  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_PAIR      = 3'd0;
  localparam logic [2:0] ST_BAD_PAIR  = 3'd1;
  localparam logic [2:0] ST_READ_NONE = 3'd2;
  localparam logic [2:0] ST_MATE_NONE = 3'd3;
  localparam logic [2:0] ST_BOTH_NONE = 3'd4;
  localparam logic [2:0] ST_SKIPPED   = 3'd5;
  localparam logic [2:0] ST_CLOSED    = 3'd6;
  localparam logic [2:0] ST_UNHANDLED = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_INSERT_LOWER = 3'd0;
  localparam logic [2:0] CFG_INSERT_UPPER = 3'd1;
  localparam logic [2:0] CFG_READ_LEN     = 3'd2;
  localparam logic [2:0] CFG_MATE_LEN     = 3'd3;
  localparam logic [2:0] CFG_OUT_LIMIT    = 3'd4;
  localparam logic [2:0] CFG_POS_VACANCY  = 3'd5;
  localparam logic [2:0] CFG_META_VACANCY = 3'd6;

  typedef struct packed {
    logic [31:0] pos;
    logic        strand;
    logic [7:0]  mism;
  } hit_t;

  typedef struct packed {
    logic vld;
    hit_t hit;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } chain_ctl_t;

  typedef struct packed {
    hit_t hit;
    logic from_mate;
  } entry_t;

  localparam int unsigned HIT_W   = $bits(hit_t);
  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: src/paired_end_window_pairing.sv
// -----------------------------------------------------------------------------
// paired_end_window_pairing
// Pairs read and mate alignment hits whose insert size falls in a window.
// -----------------------------------------------------------------------------
// Usage: beats on start_i/busy_o. Mode read or mate loads one hit per cycle
// (busy_o stays low); each hit is written to its list RAM and inserted into a
// row of sorting cells. An end marker raises busy_o until its last result.
// Config: cfg_valid_i/cfg_ready_o write beats, index and data; ready is always
// high, writes are expected only while busy_o is low.
// End marker: a bare status is a single result from the BARE state. Pairing
// first shifts the sorted rows into the list RAMs, then runs the two window
// passes, each RAM probe (left hits, right start scan, right window scan) a
// request state and a result state, and writes each pair as read leg then mate
// leg; a single list copy reads and writes each hit in turn. Results then stream
// from the pair buffer RAM; each registered read of that RAM sets the pace.
// Results: result_valid_o strobes each for one cycle, last_o on the final
// one; the receiver cannot stall. Reset clears the lists, counts, control and
// configuration registers to their defaults; payload registers are not reset.
// -----------------------------------------------------------------------------
module paired_end_window_pairing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] position_i,
  input  logic        strand_i,
  input  logic [7:0]  mismatches_i,
  input  logic [1:0]  read_list_status_i,
  input  logic [1:0]  mate_list_status_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic        has_entry_o,
  output logic [31:0] out_position_o,
  output logic        out_strand_o,
  output logic [7:0]  out_mismatches_o,
  output logic        from_mate_o,
  output logic [2:0]  pair_status_o,
  output logic        last_o
);

  localparam int unsigned CntW    = pewp_pkg::CNT_W;
  localparam int unsigned AddrW   = pewp_pkg::ADDR_W;
  localparam int unsigned BufCntW = pewp_pkg::BUF_CNT_W;
  localparam int unsigned BufAW   = pewp_pkg::BUF_ADDR_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DUMP    = 4'd1;
  localparam logic [3:0] S_LREQ    = 4'd2;
  localparam logic [3:0] S_LGOT    = 4'd3;
  localparam logic [3:0] S_RSREQ   = 4'd4;
  localparam logic [3:0] S_RSGOT   = 4'd5;
  localparam logic [3:0] S_WREQ    = 4'd6;
  localparam logic [3:0] S_WGOT    = 4'd7;
  localparam logic [3:0] S_PUSH2   = 4'd8;
  localparam logic [3:0] S_PASSEND = 4'd9;
  localparam logic [3:0] S_BADM    = 4'd10;
  localparam logic [3:0] S_CREQ    = 4'd11;
  localparam logic [3:0] S_CGOT    = 4'd12;
  localparam logic [3:0] S_OREQ    = 4'd13;
  localparam logic [3:0] S_OEMIT   = 4'd14;
  localparam logic [3:0] S_BARE    = 4'd15;

  // configuration
  logic [31:0] lower_q, upper_q;
  logic [15:0] rlen_q, mlen_q, pvac_q, mvac_q;
  logic [16:0] lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 32'd0;
      upper_q <= 32'd1000;
      rlen_q  <= 16'd100;
      mlen_q  <= 16'd100;
      lim_q   <= '1;
      pvac_q  <= 16'd128;
      mvac_q  <= 16'd128;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pewp_pkg::CFG_INSERT_LOWER: lower_q <= cfg_data_i;
        pewp_pkg::CFG_INSERT_UPPER: upper_q <= cfg_data_i;
        pewp_pkg::CFG_READ_LEN:     rlen_q  <= cfg_data_i[15:0];
        pewp_pkg::CFG_MATE_LEN:     mlen_q  <= cfg_data_i[15:0];
        pewp_pkg::CFG_OUT_LIMIT:    lim_q   <= cfg_data_i[16:0];
        pewp_pkg::CFG_POS_VACANCY:  pvac_q  <= cfg_data_i[15:0];
        pewp_pkg::CFG_META_VACANCY: mvac_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [3:0]         state_q, state_d;
  logic [CntW-1:0]    rc_q, rc_d, mc_q, mc_d;
  logic [CntW-1:0]    l_q, l_d, rs_q, rs_d, i_q, i_d;
  logic [BufCntW-1:0] pc_q, pc_d, cnt_q, cnt_d;
  logic [BufAW-1:0]   o_q, o_d;
  logic [2:0]         status_q, status_d;
  logic               pass_q, pass_d, copy_mate_q, copy_mate_d;

  // payload state
  logic [31:0]    prev_q, prev_d;
  logic [32:0]    lo_q, lo_d, hi_q, hi_d;
  pewp_pkg::hit_t left_q, left_d, right_q, right_d;
  pewp_pkg::hit_t sel_r_q, sel_r_d, sel_m_q, sel_m_d;
  logic [7:0]     least_r_q, least_r_d, least_m_q, least_m_d;

  logic accept;
  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  pewp_pkg::hit_t in_hit;
  assign in_hit = '{pos: position_i, strand: strand_i, mism: mismatches_i};

  // sorting rows
  pewp_pkg::chain_ctl_t read_ctl, mate_ctl;
  pewp_pkg::slot_t      read_head, mate_head;
  logic                 done;

  assign done = ((state_q == S_OEMIT) && last_o) || (state_q == S_BARE);

  assign read_ctl.ins   = accept && (mode_i == pewp_pkg::MODE_READ) &&
                          (rc_q < CntW'(pewp_pkg::LIST_DEPTH));
  assign read_ctl.shift = (state_q == S_DUMP);
  assign read_ctl.clr   = done;
  assign mate_ctl.ins   = accept && (mode_i == pewp_pkg::MODE_MATE) &&
                          (mc_q < CntW'(pewp_pkg::LIST_DEPTH));
  assign mate_ctl.shift = (state_q == S_DUMP);
  assign mate_ctl.clr   = done;

  pewp_chain u_read_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (read_ctl),
    .new_hit_i (in_hit),
    .head_o    (read_head)
  );

  pewp_chain u_mate_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mate_ctl),
    .new_hit_i (in_hit),
    .head_o    (mate_head)
  );

  // list RAMs: arrival order while loading, sorted order after the dump
  logic                      dumping, copying, right_scan;
  logic [AddrW-1:0]          right_addr, read_raddr, mate_raddr;
  logic                      read_we, mate_we;
  logic [AddrW-1:0]          read_waddr, mate_waddr;
  pewp_pkg::hit_t            read_wdata, mate_wdata;
  logic [pewp_pkg::HIT_W-1:0] read_rdata, mate_rdata;
  pewp_pkg::hit_t            read_rd, mate_rd;

  assign dumping    = (state_q == S_DUMP);
  assign copying    = (state_q == S_CREQ) || (state_q == S_CGOT);
  assign right_scan = (state_q == S_RSREQ) || (state_q == S_RSGOT);
  assign right_addr = right_scan ? AddrW'(rs_q) : AddrW'(i_q);

  assign read_we    = read_ctl.ins || (dumping && (l_q < rc_q));
  assign read_waddr = dumping ? AddrW'(l_q) : AddrW'(rc_q);
  assign read_wdata = dumping ? read_head.hit : in_hit;
  assign mate_we    = mate_ctl.ins || (dumping && (l_q < mc_q));
  assign mate_waddr = dumping ? AddrW'(l_q) : AddrW'(mc_q);
  assign mate_wdata = dumping ? mate_head.hit : in_hit;

  assign read_raddr = copying ? AddrW'(pc_q) : (pass_q ? right_addr : AddrW'(l_q));
  assign mate_raddr = copying ? AddrW'(pc_q) : (pass_q ? AddrW'(l_q) : right_addr);

  pewp_ram #(.Width(pewp_pkg::HIT_W), .Depth(pewp_pkg::LIST_DEPTH)) u_read_ram (
    .clk_i   (clk_i),
    .we_i    (read_we),
    .waddr_i (read_waddr),
    .wdata_i (read_wdata),
    .raddr_i (read_raddr),
    .rdata_o (read_rdata)
  );

  pewp_ram #(.Width(pewp_pkg::HIT_W), .Depth(pewp_pkg::LIST_DEPTH)) u_mate_ram (
    .clk_i   (clk_i),
    .we_i    (mate_we),
    .waddr_i (mate_waddr),
    .wdata_i (mate_wdata),
    .raddr_i (mate_raddr),
    .rdata_o (mate_rdata)
  );

  assign read_rd = read_rdata;
  assign mate_rd = mate_rdata;

  // pair buffer
  logic                         buf_we;
  pewp_pkg::entry_t             buf_wdata;
  logic [pewp_pkg::ENTRY_W-1:0] buf_rdata;
  pewp_pkg::entry_t             buf_rd;

  pewp_ram #(.Width(pewp_pkg::ENTRY_W), .Depth(pewp_pkg::BUF_DEPTH)) u_pair_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (BufAW'(pc_q)),
    .wdata_i (buf_wdata),
    .raddr_i (o_q),
    .rdata_o (buf_rdata)
  );

  assign buf_rd = buf_rdata;

  // pass roles
  pewp_pkg::hit_t  left_rd, right_rd, copy_rd;
  logic [CntW-1:0] ln, rn, dmax, n_single;
  logic [15:0]     rlen;
  logic [32:0]     rsum;
  logic [16:0]     pcx, nx;
  logic            vac_full, max_full, lim_hit;

  assign left_rd  = pass_q ? mate_rd : read_rd;
  assign right_rd = pass_q ? read_rd : mate_rd;
  assign copy_rd  = copy_mate_q ? mate_rd : read_rd;
  assign ln       = pass_q ? mc_q : rc_q;
  assign rn       = pass_q ? rc_q : mc_q;
  assign rlen     = pass_q ? rlen_q : mlen_q;
  assign rsum     = {1'b0, right_rd.pos} + {17'd0, rlen};
  assign dmax     = (rc_q > mc_q) ? rc_q : mc_q;
  assign n_single = (rc_q == '0) ? mc_q : rc_q;
  assign nx       = 17'(n_single);
  assign pcx      = 17'(pc_q);
  assign vac_full = (pcx + 17'd2) > {1'b0, pvac_q};
  assign max_full = pc_q >= BufCntW'(pewp_pkg::MAX_PAIR_OUTPUTS);
  assign lim_hit  = !lim_q[16] && (pcx >= lim_q);

  always_comb begin
    state_d     = state_q;
    rc_d        = rc_q;
    mc_d        = mc_q;
    l_d         = l_q;
    rs_d        = rs_q;
    i_d         = i_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    o_d         = o_q;
    status_d    = status_q;
    pass_d      = pass_q;
    copy_mate_d = copy_mate_q;
    prev_d      = prev_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    left_d      = left_q;
    right_d     = right_q;
    sel_r_d     = sel_r_q;
    sel_m_d     = sel_m_q;
    least_r_d   = least_r_q;
    least_m_d   = least_m_q;
    buf_we      = 1'b0;
    buf_wdata   = '{hit: sel_r_q, from_mate: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (read_ctl.ins) rc_d = rc_q + CntW'(1);
        if (mate_ctl.ins) mc_d = mc_q + CntW'(1);
        if (accept && (mode_i == pewp_pkg::MODE_END)) begin
          pc_d   = '0;
          l_d    = '0;
          pass_d = 1'b0;
          if (read_list_status_i == pewp_pkg::LS_SKIPPED ||
              mate_list_status_i == pewp_pkg::LS_SKIPPED) begin
            status_d = pewp_pkg::ST_SKIPPED;
            state_d  = S_BARE;
          end else if ((read_list_status_i inside {pewp_pkg::LS_UNHANDLED,
                                                    pewp_pkg::LS_RESERVED}) ||
                       (mate_list_status_i inside {pewp_pkg::LS_UNHANDLED,
                                                   pewp_pkg::LS_RESERVED})) begin
            status_d = pewp_pkg::ST_CLOSED;
            state_d  = S_BARE;
          end else if (rc_q != '0 && mc_q != '0) begin
            if (pvac_q < 16'd2 || mvac_q < 16'd2) begin
              status_d = pewp_pkg::ST_UNHANDLED;
              state_d  = S_BARE;
            end else begin
              status_d = pewp_pkg::ST_PAIR;
              state_d  = S_DUMP;
            end
          end else if (rc_q == '0 && mc_q == '0) begin
            status_d = pewp_pkg::ST_BOTH_NONE;
            state_d  = S_BARE;
          end else begin
            copy_mate_d = (rc_q == '0);
            status_d    = (rc_q == '0) ? pewp_pkg::ST_READ_NONE : pewp_pkg::ST_MATE_NONE;
            cnt_d       = (!lim_q[16] && (nx > lim_q)) ? BufCntW'(lim_q)
                                                       : BufCntW'(n_single);
            if (nx > {1'b0, pvac_q} || nx > {1'b0, mvac_q}) begin
              status_d = pewp_pkg::ST_UNHANDLED;
              state_d  = S_BARE;
            end else if (cnt_d == '0) begin
              state_d = S_BARE;
            end else begin
              state_d = S_CREQ;
            end
          end
        end
      end

      // sorted rows go out head first; least-mismatch hits picked on the way
      S_DUMP: begin
        if (l_q < rc_q) begin
          if (l_q == '0) begin
            sel_r_d   = read_head.hit;
            least_r_d = (read_head.hit.mism < pewp_pkg::LEAST_START) ?
                        read_head.hit.mism : pewp_pkg::LEAST_START;
          end else if (read_head.hit.mism < least_r_q) begin
            sel_r_d   = read_head.hit;
            least_r_d = read_head.hit.mism;
          end
        end
        if (l_q < mc_q) begin
          if (l_q == '0) begin
            sel_m_d   = mate_head.hit;
            least_m_d = (mate_head.hit.mism < pewp_pkg::LEAST_START) ?
                        mate_head.hit.mism : pewp_pkg::LEAST_START;
          end else if (mate_head.hit.mism < least_m_q) begin
            sel_m_d   = mate_head.hit;
            least_m_d = mate_head.hit.mism;
          end
        end
        if ((l_q + CntW'(1)) == dmax) begin
          l_d     = '0;
          rs_d    = '0;
          state_d = S_LREQ;
        end else begin
          l_d = l_q + CntW'(1);
        end
      end

      S_LREQ: begin
        state_d = (l_q >= ln) ? S_PASSEND : S_LGOT;
      end

      S_LGOT: begin
        prev_d = left_rd.pos;
        if ((l_q != '0 && left_rd.pos == prev_q) || left_rd.strand) begin
          l_d     = l_q + CntW'(1);
          state_d = S_LREQ;
        end else begin
          left_d  = left_rd;
          lo_d    = {1'b0, left_rd.pos} + {1'b0, lower_q};
          hi_d    = {1'b0, left_rd.pos} + {1'b0, upper_q};
          state_d = S_RSREQ;
        end
      end

      S_RSREQ: begin
        state_d = (rs_q >= rn) ? S_PASSEND : S_RSGOT;
      end

      S_RSGOT: begin
        if (lo_q > rsum || !right_rd.strand) begin
          rs_d    = rs_q + CntW'(1);
          state_d = S_RSREQ;
        end else begin
          i_d     = rs_q;
          state_d = S_WREQ;
        end
      end

      S_WREQ: begin
        if (i_q >= rn) begin
          l_d     = l_q + CntW'(1);
          state_d = S_LREQ;
        end else begin
          state_d = S_WGOT;
        end
      end

      S_WGOT: begin
        right_d = right_rd;
        if (hi_q < rsum) begin
          l_d     = l_q + CntW'(1);
          state_d = S_LREQ;
        end else if (!right_rd.strand) begin
          i_d     = i_q + CntW'(1);
          state_d = S_WREQ;
        end else if (vac_full) begin
          status_d = pewp_pkg::ST_UNHANDLED;
          state_d  = S_PASSEND;
        end else if (max_full) begin
          status_d = pewp_pkg::ST_CLOSED;
          state_d  = S_PASSEND;
        end else if (lim_hit) begin
          state_d = S_PASSEND;
        end else begin
          // read leg first
          buf_we    = 1'b1;
          buf_wdata = '{hit: pass_q ? right_rd : left_q, from_mate: 1'b0};
          pc_d      = pc_q + BufCntW'(1);
          state_d   = S_PUSH2;
        end
      end

      S_PUSH2: begin
        buf_we    = 1'b1;
        buf_wdata = '{hit: pass_q ? left_q : right_q, from_mate: 1'b1};
        pc_d      = pc_q + BufCntW'(1);
        i_d       = i_q + CntW'(1);
        state_d   = S_WREQ;
      end

      S_PASSEND: begin
        if (status_q == pewp_pkg::ST_UNHANDLED || status_q == pewp_pkg::ST_CLOSED) begin
          pc_d    = '0;
          state_d = S_BARE;
        end else if (!pass_q) begin
          pass_d  = 1'b1;
          l_d     = '0;
          rs_d    = '0;
          state_d = S_LREQ;
        end else if (pc_q == '0) begin
          status_d  = pewp_pkg::ST_BAD_PAIR;
          buf_we    = 1'b1;
          buf_wdata = '{hit: sel_r_q, from_mate: 1'b0};
          pc_d      = pc_q + BufCntW'(1);
          state_d   = S_BADM;
        end else begin
          o_d     = '0;
          state_d = S_OREQ;
        end
      end

      S_BADM: begin
        buf_we    = 1'b1;
        buf_wdata = '{hit: sel_m_q, from_mate: 1'b1};
        pc_d      = pc_q + BufCntW'(1);
        o_d       = '0;
        state_d   = S_OREQ;
      end

      S_CREQ: begin
        state_d = S_CGOT;
      end

      S_CGOT: begin
        buf_we    = 1'b1;
        buf_wdata = '{hit: copy_rd, from_mate: copy_mate_q};
        pc_d      = pc_q + BufCntW'(1);
        if ((pc_q + BufCntW'(1)) == cnt_q) begin
          o_d     = '0;
          state_d = S_OREQ;
        end else begin
          state_d = S_CREQ;
        end
      end

      S_OREQ: begin
        state_d = S_OEMIT;
      end

      S_OEMIT: begin
        if (last_o) begin
          rc_d    = '0;
          mc_d    = '0;
          state_d = S_IDLE;
        end else begin
          o_d     = o_q + BufAW'(1);
          state_d = S_OREQ;
        end
      end

      S_BARE: begin
        rc_d    = '0;
        mc_d    = '0;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rc_q        <= '0;
      mc_q        <= '0;
      l_q         <= '0;
      rs_q        <= '0;
      i_q         <= '0;
      pc_q        <= '0;
      cnt_q       <= '0;
      o_q         <= '0;
      status_q    <= pewp_pkg::ST_PAIR;
      pass_q      <= 1'b0;
      copy_mate_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rc_q        <= rc_d;
      mc_q        <= mc_d;
      l_q         <= l_d;
      rs_q        <= rs_d;
      i_q         <= i_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      o_q         <= o_d;
      status_q    <= status_d;
      pass_q      <= pass_d;
      copy_mate_q <= copy_mate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q    <= prev_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    left_q    <= left_d;
    right_q   <= right_d;
    sel_r_q   <= sel_r_d;
    sel_m_q   <= sel_m_d;
    least_r_q <= least_r_d;
    least_m_q <= least_m_d;
  end

  // result beats
  logic emit;
  assign emit             = (state_q == S_OEMIT);
  assign result_valid_o   = emit || (state_q == S_BARE);
  assign has_entry_o      = emit;
  assign out_position_o   = emit ? buf_rd.hit.pos : '0;
  assign out_strand_o     = emit ? buf_rd.hit.strand : 1'b0;
  assign out_mismatches_o = emit ? buf_rd.hit.mism : '0;
  assign from_mate_o      = emit ? buf_rd.from_mate : 1'b0;
  assign pair_status_o    = status_q;
  assign last_o           = (state_q == S_BARE) ||
                            (emit && ((BufCntW'(o_q) + BufCntW'(1)) == pc_q));

`ifndef NO_ASSERTIONS
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result beat outside an end marker");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy_o)
    else $error("block still busy after last result");

  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q <= CntW'(pewp_pkg::LIST_DEPTH)) && (mc_q <= CntW'(pewp_pkg::LIST_DEPTH)))
    else $error("hit list count beyond depth");

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= BufCntW'(pewp_pkg::BUF_DEPTH))
    else $error("pair buffer overfilled");
`endif

endmodule

// File: src/pewp_ram.sv
// -----------------------------------------------------------------------------
// pewp_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module pewp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pewp_cell.sv
// -----------------------------------------------------------------------------
// pewp_cell
// One slot of the sorting row: keeps its hit, takes the new hit, or takes a
// neighbour's hit so that the row stays ordered by position.
// -----------------------------------------------------------------------------
module pewp_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pewp_pkg::chain_ctl_t ctl_i,
  input  pewp_pkg::hit_t       new_hit_i,
  input  pewp_pkg::slot_t      left_i,
  input  logic                 left_keep_i,
  input  pewp_pkg::slot_t      right_i,
  output pewp_pkg::slot_t      slot_o,
  output logic                 keep_o
);

  logic           vld_q, vld_d;
  pewp_pkg::hit_t hit_q, hit_d;

  // equal positions stay put: new hit lands behind them
  assign keep_o = vld_q && (hit_q.pos <= new_hit_i.pos);

  always_comb begin
    vld_d = vld_q;
    hit_d = hit_q;
    if (ctl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctl_i.shift) begin
      vld_d = right_i.vld;
      hit_d = right_i.hit;
    end else if (ctl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        vld_d = 1'b1;
        hit_d = new_hit_i;
      end else begin
        vld_d = left_i.vld;
        hit_d = left_i.hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign slot_o = '{vld: vld_q, hit: hit_q};

endmodule

// File: src/pewp_chain.sv
// -----------------------------------------------------------------------------
// pewp_chain
// Row of sorting cells for one hit list; shifts out in order from the head.
// -----------------------------------------------------------------------------
module pewp_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pewp_pkg::chain_ctl_t ctl_i,
  input  pewp_pkg::hit_t       new_hit_i,
  output pewp_pkg::slot_t      head_o
);

  pewp_pkg::slot_t slots [pewp_pkg::LIST_DEPTH];
  logic            keeps [pewp_pkg::LIST_DEPTH];

  for (genvar g = 0; g < pewp_pkg::LIST_DEPTH; g++) begin : g_cell
    pewp_pkg::slot_t left, right;
    logic            left_keep;

    if (g == 0) begin : g_first
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = slots[g-1];
      assign left_keep = keeps[g-1];
    end

    if (g == pewp_pkg::LIST_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = slots[g+1];
    end

    pewp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .new_hit_i   (new_hit_i),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .slot_o      (slots[g]),
      .keep_o      (keeps[g])
    );
  end

  assign head_o = slots[0];

endmodule
